// File: sv/sortpq_pkg.sv
`timescale 1ns / 1ps
// Shared types and sizing constants for the sorted priority queue.
// No dependencies; imported by the queue and its checker.
package sortpq_pkg;

  localparam int CAPACITY      = 16;
  localparam int VALUE_BITS    = 32;
  localparam int PRIORITY_BITS = 16;

  localparam int OCC_W   = $clog2(CAPACITY + 1);
  localparam int FIELD_V = 32;
  localparam int FIELD_P = 16;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_EXTRACT = 2'd1,
    MODE_MODIFY  = 2'd2,
    MODE_STATUS  = 2'd3
  } op_mode_t;

  typedef struct packed {
    logic        [VALUE_BITS-1:0]    value;
    logic signed [PRIORITY_BITS-1:0] prio;
  } entry_t;

endpackage

// File: sv/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Path from input transfer to result: input register, then result register.
// One item per cycle unless out_stall holds back a result; each item updates all slots
// through parallel compares and shifts, and the next item sees the updated slots.
// Reset: synchronous, active high; clears the occupancy and both valid flags.
// Slot contents are not cleared; only slots below the occupancy are ever read.
module sorted_priority_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         mode,
  input  logic [sortpq_pkg::FIELD_V-1:0]     item_value,
  input  logic signed [sortpq_pkg::FIELD_P-1:0] item_priority,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               removed_valid,
  output logic [sortpq_pkg::FIELD_V-1:0]     removed_value,
  output logic signed [sortpq_pkg::FIELD_P-1:0] removed_priority,
  output logic                               head_valid,
  output logic [sortpq_pkg::FIELD_V-1:0]     head_value,
  output logic signed [sortpq_pkg::FIELD_P-1:0] head_priority,
  output logic [sortpq_pkg::COUNT_W-1:0]     entry_count,
  output logic                               key_found,
  output logic                               overflow
);
  import sortpq_pkg::*;

  // Input register.
  logic                            s1_valid;
  op_mode_t                        s1_mode;
  logic [VALUE_BITS-1:0]           s1_value;
  logic signed [PRIORITY_BITS-1:0] s1_priority;

  // Queue storage, kept sorted with the head in slot 0.
  entry_t           slots [CAPACITY];
  entry_t           slots_next [CAPACITY];
  logic [OCC_W-1:0] occupancy;
  logic [OCC_W-1:0] occupancy_next;

  logic advance;

  // Step results.
  logic   rm;
  logic   ins;
  logic   found;
  logic   ovf;
  entry_t removed_entry;

  assign advance  = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && !advance;

  always_comb begin
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] shift;
    logic [CAPACITY-1:0] le;
    entry_t              comp [CAPACITY];
    entry_t              new_entry;
    logic [OCC_W-1:0]    occ_comp;
    logic                full;
    logic                seen;

    full = (occupancy == OCC_W'(CAPACITY));
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (OCC_W'(i) < occupancy) && (slots[i].value == s1_value);
    end
    found = 1'b0;
    ovf   = 1'b0;
    rm    = 1'b0;
    ins   = 1'b0;
    unique case (s1_mode)
      MODE_INSERT: begin
        ovf = full;
        ins = !full;
      end
      MODE_EXTRACT: begin
        rm = (occupancy != '0);
      end
      MODE_MODIFY: begin
        found = |match;
        rm    = found;
        ins   = found;
      end
      MODE_STATUS: begin
      end
      default: begin
      end
    endcase

    // Slots at and above the removed entry move down by one.
    seen = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (s1_mode == MODE_EXTRACT) begin
        shift[i] = 1'b1;
      end else begin
        seen     = seen | (match[i] && s1_mode == MODE_MODIFY);
        shift[i] = seen;
      end
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      comp[i] = (rm && shift[i]) ? slots[i+1] : slots[i];
    end
    comp[CAPACITY-1] = slots[CAPACITY-1];
    occ_comp = occupancy - OCC_W'(rm);

    // The list is sorted, so the entries not above the new priority form a prefix.
    // A new entry goes after every entry of equal priority.
    for (int i = 0; i < CAPACITY; i++) begin
      le[i] = (OCC_W'(i) < occ_comp) && (comp[i].prio <= s1_priority);
    end
    new_entry.value = s1_value;
    new_entry.prio  = s1_priority;
    if (!ins || le[0]) begin
      slots_next[0] = comp[0];
    end else begin
      slots_next[0] = new_entry;
    end
    for (int i = 1; i < CAPACITY; i++) begin
      if (!ins || le[i]) begin
        slots_next[i] = comp[i];
      end else if (le[i-1]) begin
        slots_next[i] = new_entry;
      end else begin
        slots_next[i] = comp[i-1];
      end
    end
    occupancy_next = occ_comp + OCC_W'(ins);
    removed_entry  = slots[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mode     <= op_mode_t'(mode);
      s1_value    <= VALUE_BITS'(item_value);
      s1_priority <= PRIORITY_BITS'(item_priority);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (advance) begin
      occupancy <= occupancy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < CAPACITY; i++) begin
        slots[i] <= slots_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      removed_valid    <= rm && s1_mode == MODE_EXTRACT;
      removed_value    <= (rm && s1_mode == MODE_EXTRACT)
                          ? FIELD_V'(removed_entry.value) : '0;
      removed_priority <= (rm && s1_mode == MODE_EXTRACT)
                          ? FIELD_P'(removed_entry.prio) : '0;
      head_valid       <= (occupancy_next != '0);
      head_value       <= (occupancy_next != '0) ? FIELD_V'(slots_next[0].value) : '0;
      head_priority    <= (occupancy_next != '0) ? FIELD_P'(slots_next[0].prio) : '0;
      entry_count      <= COUNT_W'(occupancy_next);
      key_found        <= found;
      overflow         <= ovf;
    end
  end

endmodule

// File: sv/sortpq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on sortpq_pkg and sorted_priority_queue.
module sortpq_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               removed_valid,
  input logic signed [sortpq_pkg::FIELD_P-1:0] removed_priority,
  input logic                               head_valid,
  input logic [sortpq_pkg::FIELD_V-1:0]     head_value,
  input logic signed [sortpq_pkg::FIELD_P-1:0] head_priority,
  input logic [sortpq_pkg::COUNT_W-1:0]     entry_count,
  input logic                               overflow
);
  import sortpq_pkg::*;

  // The head is reported exactly when the queue holds entries.
  a_head_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (head_valid == (entry_count != '0)))
    else $error("head_valid disagrees with entry_count");

  // An overflow can only be reported by a full queue.
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (entry_count == COUNT_W'(CAPACITY)))
    else $error("overflow reported while the queue has room");

  // Extract serves the smallest priority, so the new head is never smaller.
  a_extract_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && removed_valid && head_valid) |-> (head_priority >= removed_priority))
    else $error("extracted entry was not the smallest priority");

  // A result held back by stall stays on the ports.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(head_value) && $stable(entry_count)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue sortpq_checker u_sortpq_checker (.*);
